@@ hdl/atrsc_pkg.sv @@
// ----------------------------------------------------------------------------
// atrsc_pkg
// shared types, constants and helpers of the answer-to-reset classifier
// ----------------------------------------------------------------------------
package atrsc_pkg;

    typedef enum logic [1:0] {
        PH_TS    = 2'd0,
        PH_T0    = 2'd1,
        PH_IFACE = 2'd2,
        PH_HIST  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CLS_UNKNOWN     = 2'd0,
        CLS_ISO15693    = 2'd1,
        CLS_TYPE_B      = 2'd2,
        CLS_CONTACTLESS = 2'd3
    } t_card_class;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam int unsigned HIST_KEEP = 9;
    localparam int unsigned SEEN_W    = 4;

    localparam logic [7:0] TS_DIRECT    = 8'h3B;
    localparam logic [7:0] AID_TAG      = 8'h4F;
    localparam logic [7:0] AID_MIN_LEN  = 8'h08;
    localparam logic [7:0] SS_15693_LO  = 8'h09;
    localparam logic [7:0] SS_15693_HI  = 8'h0C;
    localparam logic [7:0] TYPE_B_FIRST = 8'h50;
    localparam logic [3:0] TYPE_B_HLEN  = 4'd12;
    localparam logic [1:0] TD_LEVEL_MAX = 2'd3;

    // registered application provider id, lowest byte first
    localparam logic [4:0][7:0] PCSC_RID = {8'h06, 8'h03, 8'h00, 8'h00, 8'hA0};

    typedef logic [HIST_KEEP-1:0][7:0] t_hist;

    // parser summary handed to the classifier
    typedef struct packed {
        logic       short_atr;
        logic       direct;
        logic       in_iface;
        logic [3:0] hcount;
        t_hist      hist;
    } t_class_in;

    // number of TA/TB/TC presence bits in a T0 or TD byte
    function automatic logic [1:0] count_abc(input logic [7:0] b);
        return {1'b0, b[4]} + {1'b0, b[5]} + {1'b0, b[6]};
    endfunction

endpackage

@@ hdl/atrsc_classify.sv @@
// ----------------------------------------------------------------------------
// atrsc_classify
// card class and status from the parser state at the end of an atr
// ----------------------------------------------------------------------------
module atrsc_classify (
    input  atrsc_pkg::t_class_in i_sum,
    output logic [1:0]           o_card_class,
    output logic [1:0]           o_status
);

    logic is_storage;
    logic ss_15693;

    always_comb begin
        is_storage = (i_sum.hcount >= 4'd3)
                  && (i_sum.hist[1] == atrsc_pkg::AID_TAG)
                  && (i_sum.hist[2] >= atrsc_pkg::AID_MIN_LEN)
                  && (i_sum.hist[7:3] == atrsc_pkg::PCSC_RID);
        ss_15693   = (i_sum.hist[8] >= atrsc_pkg::SS_15693_LO)
                  && (i_sum.hist[8] <= atrsc_pkg::SS_15693_HI);
    end

    always_comb begin
        o_card_class = atrsc_pkg::CLS_UNKNOWN;
        o_status     = atrsc_pkg::ST_OK;
        priority if (i_sum.short_atr) begin
            o_status = atrsc_pkg::ST_SHORT;
        end else if (!i_sum.direct) begin
            o_card_class = atrsc_pkg::CLS_UNKNOWN;
        end else if (i_sum.in_iface) begin
            o_status = atrsc_pkg::ST_TRUNCATED;
        end else if (i_sum.hcount == 4'd0) begin
            o_card_class = atrsc_pkg::CLS_UNKNOWN;
        end else if (is_storage) begin
            o_card_class = ss_15693 ? atrsc_pkg::CLS_ISO15693 : atrsc_pkg::CLS_UNKNOWN;
        end else if (i_sum.hcount == atrsc_pkg::TYPE_B_HLEN
                     && i_sum.hist[0] == atrsc_pkg::TYPE_B_FIRST) begin
            o_card_class = atrsc_pkg::CLS_TYPE_B;
        end else begin
            o_card_class = atrsc_pkg::CLS_CONTACTLESS;
        end
    end

endmodule

@@ hdl/atr_structure_classifier.sv @@
// ----------------------------------------------------------------------------
// atr_structure_classifier
// byte-wise answer-to-reset parser that classifies the card at the last byte
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_ready) carries one atr word: i_atr_byte and
//   i_is_last, TS first. output channel (o_valid / i_ready) carries one word
//   per atr, o_card_class and o_status, produced by the word flagged last.
//   words that are not last produce nothing on the output.
// timing:
//   a word is held in the input register, then the parser update and the
//   classification run in one pass into the output register, which drives
//   o_valid. throughput is one word per cycle while no last word waits for
//   the result slot.
// stall:
//   while the output register holds an untaken result, non-last words keep
//   flowing; a last word waits in the input register until the result slot
//   frees, and o_ready stays low while it waits.
// reset:
//   synchronous, active low; the parser returns to expect TS with an empty
//   historical store, and both registers are emptied. the parser also
//   returns to that state after every last word.
// ----------------------------------------------------------------------------
module atr_structure_classifier #(
    parameter int unsigned MAX_ATR_BYTES = 33
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_atr_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_card_class,
    output logic [1:0] o_status
);

    localparam int unsigned POS_W = $clog2(MAX_ATR_BYTES + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    atrsc_pkg::t_phase           r_phase, n_phase;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic                        r_direct, n_direct;
    logic [1:0]                  r_pend, n_pend;
    logic [1:0]                  r_level, n_level;
    logic                        r_pend_td, n_pend_td;
    logic [3:0]                  r_hcount, n_hcount;
    logic [atrsc_pkg::SEEN_W-1:0] r_hseen, n_hseen;
    atrsc_pkg::t_hist            r_hist, n_hist;

    // output register
    logic       r_out_valid;
    logic [1:0] r_out_class;
    logic [1:0] r_out_status;

    logic                 go;
    logic                 take;
    logic [1:0]           abc;
    atrsc_pkg::t_class_in sum;
    logic [1:0]           cls_class;
    logic [1:0]           cls_status;

    // a last word needs the result slot, other words never wait
    assign go      = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || go;
    assign take    = r_pos < POS_W'(MAX_ATR_BYTES);
    assign abc     = atrsc_pkg::count_abc(r_in_byte);

    // parser update for the word in the input register
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_direct  = r_direct;
        n_pend    = r_pend;
        n_level   = r_level;
        n_pend_td = r_pend_td;
        n_hcount  = r_hcount;
        n_hseen   = r_hseen;
        n_hist    = r_hist;
        if (take) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                atrsc_pkg::PH_TS: begin
                    n_direct = (r_in_byte == atrsc_pkg::TS_DIRECT);
                    n_phase  = atrsc_pkg::PH_T0;
                end
                atrsc_pkg::PH_T0: begin
                    n_hcount  = r_in_byte[3:0];
                    n_pend    = abc;
                    n_pend_td = r_in_byte[7];
                    n_level   = 2'd1;
                end
                atrsc_pkg::PH_IFACE: begin
                    priority if (r_pend != 2'd0) begin
                        n_pend = r_pend - 2'd1;
                    end else if (r_level < atrsc_pkg::TD_LEVEL_MAX) begin
                        // TD1 or TD2 names the next group
                        n_pend    = abc;
                        n_pend_td = r_in_byte[7];
                        n_level   = r_level + 2'd1;
                    end else begin
                        // TD3 presence bits are ignored
                        n_pend_td = 1'b0;
                    end
                end
                atrsc_pkg::PH_HIST: begin
                    if (r_hseen < atrsc_pkg::SEEN_W'(atrsc_pkg::HIST_KEEP)) begin
                        for (int i = 0; i < atrsc_pkg::HIST_KEEP; i++) begin
                            if (r_hseen == atrsc_pkg::SEEN_W'(i)) begin
                                n_hist[i] = r_in_byte;
                            end
                        end
                        n_hseen = r_hseen + atrsc_pkg::SEEN_W'(1);
                    end
                end
                default: ;
            endcase
            // after T0 or an interface byte, settle on interface or historical
            if (r_phase == atrsc_pkg::PH_T0 || r_phase == atrsc_pkg::PH_IFACE) begin
                n_phase = (n_pend == 2'd0 && !n_pend_td) ? atrsc_pkg::PH_HIST
                                                         : atrsc_pkg::PH_IFACE;
            end
        end
    end

    // classification sees the state after this word
    always_comb begin
        sum.short_atr = n_pos < POS_W'(2);
        sum.direct    = n_direct;
        sum.in_iface  = (n_phase == atrsc_pkg::PH_IFACE);
        sum.hcount    = n_hcount;
        sum.hist      = n_hist;
    end

    atrsc_classify u_classify (
        .i_sum        (sum),
        .o_card_class (cls_class),
        .o_status     (cls_status)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_atr_byte;
            r_in_last <= i_is_last;
        end
    end

    // parser state, cleared again after every last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (go && r_in_last)) begin
            r_phase   <= atrsc_pkg::PH_TS;
            r_pos     <= '0;
            r_direct  <= 1'b0;
            r_pend    <= 2'd0;
            r_level   <= 2'd0;
            r_pend_td <= 1'b0;
            r_hcount  <= 4'd0;
            r_hseen   <= '0;
            r_hist    <= '0;
        end else if (go) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_direct  <= n_direct;
            r_pend    <= n_pend;
            r_level   <= n_level;
            r_pend_td <= n_pend_td;
            r_hcount  <= n_hcount;
            r_hseen   <= n_hseen;
            r_hist    <= n_hist;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (go && r_in_last) begin
            r_out_class  <= cls_class;
            r_out_status <= cls_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_card_class = r_out_class;
    assign o_status     = r_out_status;

endmodule
